>>> design/scft_pkg.sv
`default_nettype none

package scft_pkg;

  // field widths of one transaction
  localparam int FRAME_W     = 20;
  localparam int PAGE_W      = 20;
  localparam int OWNER_W     = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // one table entry as held in the frame memory
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [OWNER_W-1:0] owner;
    logic               acc;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic shift;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_end;
    logic scan_shift;
    logic shift_end;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/scft_ctrl.sv
`default_nettype none

module scft_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  scft_pkg::dp_sts_t sts,
  output scft_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = sts.scan_shift ? S_SHIFT : S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/scft_dp.sv
`default_nettype none

module scft_dp #(
  parameter int FRAME_SLOTS = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  [scft_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire  [scft_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [scft_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  scft_pkg::dp_cmd_t                    cmd,
  output scft_pkg::dp_sts_t                    sts
);

  localparam int PTR_W = $clog2(FRAME_SLOTS);
  localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
  localparam int PAD_W = scft_pkg::OUT_TDATA_W - scft_pkg::STATUS_W - scft_pkg::FRAME_W
                         - scft_pkg::PAGE_W - scft_pkg::OWNER_W;

  // frame memory, kept in insertion order
  scft_pkg::entry_t mem [FRAME_SLOTS];

  logic [CNT_W-1:0]              count_r;
  scft_pkg::cmd_t                op_r;
  logic [scft_pkg::FRAME_W-1:0]  key_r;
  logic [scft_pkg::PAGE_W-1:0]   page_r;
  logic [scft_pkg::OWNER_W-1:0]  owner_r;
  logic [PTR_W-1:0]              pos_r;
  logic                          wrap_r;
  scft_pkg::entry_t              rd_data_r;
  scft_pkg::entry_t              head_r;
  scft_pkg::entry_t              victim_r;
  scft_pkg::status_t             status_r;
  logic                          out_valid_r;
  logic [scft_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic             full;
  logic             empty;
  logic             is_last;
  logic             match;
  logic             wrap_hit;
  logic [PTR_W-1:0] pos_plus1;
  logic [PTR_W-1:0] pos_plus2;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  scft_pkg::entry_t wr_data;

  assign full      = (count_r == CNT_W'(FRAME_SLOTS));
  assign empty     = (count_r == '0);
  assign is_last   = (CNT_W'(pos_r) == (count_r - CNT_W'(1)));
  assign match     = (rd_data_r.frame == key_r);
  assign wrap_hit  = rd_data_r.acc && is_last;
  assign pos_plus1 = pos_r + PTR_W'(1);
  assign pos_plus2 = pos_r + PTR_W'(2);

  // status towards the controller
  always_comb begin
    sts            = '0;
    sts.need_scan  = (op_r != scft_pkg::CMD_INSERT) && !empty;
    sts.shift_end  = is_last;
    sts.out_free   = !out_valid_r || out_tready;
    if (op_r == scft_pkg::CMD_EVICT) begin
      sts.scan_end   = !rd_data_r.acc || is_last;
      sts.scan_shift = 1'b1;
    end else begin
      sts.scan_end   = match || is_last;
      sts.scan_shift = (op_r == scft_pkg::CMD_FREE) && match;
    end
  end

  // read address: head on scan start, next entry while scanning (entry 1 when an evict wraps), two ahead while shifting
  always_comb begin
    rd_addr = pos_plus1;
    if (cmd.exec) begin
      rd_addr = '0;
    end else if (cmd.scan && (op_r == scft_pkg::CMD_EVICT) && wrap_hit) begin
      rd_addr = PTR_W'(1);
    end else if (cmd.shift) begin
      rd_addr = pos_plus2;
    end
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = rd_data_r;
    if (cmd.exec && (op_r == scft_pkg::CMD_INSERT) && !full) begin
      wr_en         = 1'b1;
      wr_addr       = count_r[PTR_W-1:0];
      wr_data.frame = key_r;
      wr_data.page  = page_r;
      wr_data.owner = owner_r;
      wr_data.acc   = 1'b0;
    end else if (cmd.scan && (op_r == scft_pkg::CMD_TOUCH) && match) begin
      wr_en       = 1'b1;
      wr_data.acc = 1'b1;
    end else if (cmd.scan && (op_r == scft_pkg::CMD_EVICT) && rd_data_r.acc) begin
      // second chance: clear the accessed bit and move on
      wr_en       = 1'b1;
      wr_data.acc = 1'b0;
    end else if (cmd.shift && !is_last) begin
      // close up the order; after a full pass every bit is already clear
      wr_en       = 1'b1;
      wr_data.acc = rd_data_r.acc && !wrap_r;
    end
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= scft_pkg::cmd_t'(in_tuser);
      key_r   <= in_tdata[scft_pkg::FRAME_W-1:0];
      page_r  <= in_tdata[scft_pkg::FRAME_W +: scft_pkg::PAGE_W];
      owner_r <= in_tdata[scft_pkg::FRAME_W + scft_pkg::PAGE_W +: scft_pkg::OWNER_W];
    end
  end

  // scan and shift bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pos_r    <= '0;
      wrap_r   <= 1'b0;
      victim_r <= '0;
      status_r <= scft_pkg::ST_OK;
      case (op_r)
        scft_pkg::CMD_INSERT: begin
          if (full) begin
            status_r <= scft_pkg::ST_FULL;
          end
        end
        scft_pkg::CMD_EVICT: begin
          if (empty) begin
            status_r <= scft_pkg::ST_EMPTY;
          end
        end
        default: begin
          if (empty) begin
            status_r <= scft_pkg::ST_NOT_FOUND;
          end
        end
      endcase
    end else if (cmd.scan) begin
      if (op_r inside {scft_pkg::CMD_TOUCH, scft_pkg::CMD_FREE}) begin
        if (!match) begin
          if (is_last) begin
            status_r <= scft_pkg::ST_NOT_FOUND;
          end else begin
            pos_r <= pos_plus1;
          end
        end
      end else begin
        if (pos_r == '0) begin
          head_r <= rd_data_r;
        end
        if (!rd_data_r.acc) begin
          victim_r <= rd_data_r;
        end else if (is_last) begin
          // full pass with every bit set: the head goes
          victim_r <= (pos_r == '0) ? rd_data_r : head_r;
          pos_r    <= '0;
          wrap_r   <= 1'b1;
        end else begin
          pos_r <= pos_plus1;
        end
      end
    end else if (cmd.shift && !is_last) begin
      pos_r <= pos_plus1;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec && (op_r == scft_pkg::CMD_INSERT) && !full) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.shift && is_last) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {{PAD_W{1'b0}}, victim_r.owner, victim_r.page, victim_r.frame, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> design/second_chance_frame_table_top.sv
`default_nettype none

// channel | ports                          | contents (lowest bit first)
// in      | in_tvalid in_tready in_tdata   | tdata: frame_number, virtual_page, owner_id
//         | in_tuser                       | tuser: command
// out     | out_tvalid out_tready out_tdata| tdata: status, victim_frame, victim_page,
//         |                                |        victim_owner, zero fill
//
// insert and any empty-table command pass through acceptance, execute and result load
// touch, free and evict then scan the table from the head; an evict that
// finds every accessed bit set scans the whole table, then closes up all of it,
// one entry a cycle through the memory's one read port and one write port
// reset clears the control state, the entry count and the output valid flag; memory is not cleared
// a new transaction is taken while an earlier result still waits on out; input stalls once the next is ready

module second_chance_frame_table_top #(
  parameter int FRAME_SLOTS = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // frame_number [19:0], virtual_page [39:20], owner_id [47:40]
  input  wire  [scft_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command [1:0]
  input  wire  [scft_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // status [1:0], victim_frame [21:2], victim_page [41:22], victim_owner [49:42]
  output logic [scft_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  scft_pkg::dp_cmd_t dp_cmd;
  scft_pkg::dp_sts_t dp_sts;

  scft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  scft_dp #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (dp_cmd),
    .sts        (dp_sts)
  );

endmodule

`default_nettype wire

>>> tb/scft_checker.sv
`timescale 1ns / 1ps

module scft_checker #(
  parameter int FRAME_SLOTS = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  // frame_number [19:0], virtual_page [39:20], owner_id [47:40]
  input  wire  [scft_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command [1:0]
  input  wire  [scft_pkg::CMD_W-1:0]       in_tuser,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  // status [1:0], victim_frame [21:2], victim_page [41:22], victim_owner [49:42]
  input  wire  [scft_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending_results
);

  import scft_pkg::*;

  // what one transaction on the result channel should carry
  typedef struct {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [OWNER_W-1:0] owner;
  } victim_report_t;

  // shadow of the resident frame table, head at position 0
  entry_t         resident[FRAME_SLOTS];
  int             resident_count;
  victim_report_t awaited_reports[$];

  initial fail_count = 0;

  // position of the entry nearest the head holding the frame, or the count if absent
  function automatic int find_frame(input logic [FRAME_W-1:0] frame);
    for (int i = 0; i < resident_count; i++) begin
      if (resident[i].frame == frame) return i;
    end
    return resident_count;
  endfunction

  // remove one entry and close up the insertion order
  function automatic void close_up(input int pos);
    for (int i = pos; i + 1 < resident_count; i++) resident[i] = resident[i + 1];
    resident_count--;
  endfunction

  // apply one command to the shadow table and work out its report
  function automatic victim_report_t apply_command(input cmd_t cmd,
                                                   input logic [FRAME_W-1:0] frame,
                                                   input logic [PAGE_W-1:0] page,
                                                   input logic [OWNER_W-1:0] owner);
    victim_report_t rep;
    int pos;
    rep.status = ST_OK;
    rep.frame  = '0;
    rep.page   = '0;
    rep.owner  = '0;
    case (cmd)
      CMD_INSERT: begin
        if (resident_count >= FRAME_SLOTS) begin
          rep.status = ST_FULL;
        end else begin
          resident[resident_count] = '{frame: frame, page: page, owner: owner, acc: 1'b0};
          resident_count++;
        end
      end
      CMD_TOUCH: begin
        pos = find_frame(frame);
        if (pos >= resident_count) rep.status = ST_NOT_FOUND;
        else resident[pos].acc = 1'b1;
      end
      CMD_FREE: begin
        pos = find_frame(frame);
        if (pos >= resident_count) rep.status = ST_NOT_FOUND;
        else close_up(pos);
      end
      default: begin
        if (resident_count == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          // second chance sweep, wrapping at the tail; two passes at most
          pos = 0;
          for (int steps = 0; steps < 2 * resident_count; steps++) begin
            if (!resident[pos].acc) break;
            resident[pos].acc = 1'b0;
            pos++;
            if (pos >= resident_count) pos = 0;
          end
          rep.frame = resident[pos].frame;
          rep.page  = resident[pos].page;
          rep.owner = resident[pos].owner;
          close_up(pos);
        end
      end
    endcase
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // watch both channels: compare results first, then predict new transactions
  always @(posedge clk) begin
    victim_report_t want;
    if (!rst_n) begin
      awaited_reports.delete();
      resident_count = 0;
      pending_results <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_reports.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got 0x%0h", $time, out_tdata);
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("victim_frame", 32'(want.frame), 32'(out_tdata[21:2]));
          check_field("victim_page", 32'(want.page), 32'(out_tdata[41:22]));
          check_field("victim_owner", 32'(want.owner), 32'(out_tdata[49:42]));
          check_field("zero fill", 32'd0, 32'(out_tdata[OUT_TDATA_W-1:50]));
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_reports.push_back(apply_command(cmd_t'(in_tuser), in_tdata[19:0],
                                                in_tdata[39:20], in_tdata[47:40]));
      end
      pending_results <= awaited_reports.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import scft_pkg::*;

  localparam int FRAME_SLOTS = 64;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   fail_count;
  int   pending_results;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  // frames believed resident, used to aim touch and free at real entries
  logic [FRAME_W-1:0] known_frames[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  second_chance_frame_table_top #(.FRAME_SLOTS(FRAME_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  scft_checker #(.FRAME_SLOTS(FRAME_SLOTS)) frame_table_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // result side: random stalls, or a long hold-off once requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= 400;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one transaction, with an occasional gap before it
  task automatic send_item(input cmd_t cmd, input logic [FRAME_W-1:0] frame,
                           input logic [PAGE_W-1:0] page, input logic [OWNER_W-1:0] owner);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {owner, page, frame};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // rough bookkeeping of resident frames
    case (cmd)
      CMD_INSERT: if (known_frames.size() < FRAME_SLOTS) known_frames.push_back(frame);
      CMD_FREE: begin
        foreach (known_frames[i]) begin
          if (known_frames[i] == frame) begin
            known_frames.delete(i);
            break;
          end
        end
      end
      CMD_EVICT: if (known_frames.size() > 0) void'(known_frames.pop_front());
      default: ;
    endcase
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // random traffic in bursts that fill, mix or drain the table
  task automatic run_random_phase(input int items);
    int insert_pct[3] = '{70, 35, 10};
    int touch_pct[3]  = '{15, 30, 25};
    int free_pct[3]   = '{5, 15, 20};
    int sent;
    int burst;
    int mode;
    int roll;
    cmd_t cmd;
    logic [FRAME_W-1:0] frame;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(30, 90);
      mode  = $urandom_range(0, 2);
      for (int k = 0; k < burst && sent < items; k++) begin
        roll = $urandom_range(99);
        if (roll < insert_pct[mode]) cmd = CMD_INSERT;
        else if (roll < insert_pct[mode] + touch_pct[mode]) cmd = CMD_TOUCH;
        else if (roll < insert_pct[mode] + touch_pct[mode] + free_pct[mode]) cmd = CMD_FREE;
        else cmd = CMD_EVICT;
        frame = FRAME_W'($urandom);
        if (known_frames.size() > 0) begin
          // duplicates on insert now and then, mostly real targets for touch and free
          if ((cmd == CMD_INSERT && $urandom_range(99) < 15) ||
              ((cmd == CMD_TOUCH || cmd == CMD_FREE) && $urandom_range(99) < 85))
            frame = known_frames[$urandom_range(known_frames.size() - 1)];
        end
        send_item(cmd, frame, PAGE_W'($urandom), OWNER_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: evict reports empty, touch and free miss
    send_item(CMD_EVICT, 20'h0, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'h0, 20'hfffff, 8'hff);
    send_item(CMD_FREE, 20'hfffff, 20'h0, 8'h0);
    // field extremes and a duplicate frame
    send_item(CMD_INSERT, 20'h0, 20'h0, 8'h0);
    send_item(CMD_INSERT, 20'hfffff, 20'hfffff, 8'hff);
    send_item(CMD_INSERT, 20'h12345, 20'habcde, 8'h5a);
    send_item(CMD_INSERT, 20'h0, 20'h11111, 8'h11);
    // touch hits the duplicate nearest the head; evict skips the touched ones
    send_item(CMD_TOUCH, 20'h0, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'hfffff, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'h12345, 20'h0, 8'h0);
    send_item(CMD_EVICT, 20'h0, 20'h0, 8'h0);
    // every accessed bit set: sweep wraps and the head goes
    send_item(CMD_TOUCH, 20'h0, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'hfffff, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'h12345, 20'h0, 8'h0);
    send_item(CMD_EVICT, 20'h0, 20'h0, 8'h0);
    // misses, then free down to empty
    send_item(CMD_FREE, 20'h55555, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'haaaaa, 20'h0, 8'h0);
    send_item(CMD_FREE, 20'h12345, 20'h0, 8'h0);
    send_item(CMD_FREE, 20'hfffff, 20'h0, 8'h0);
    send_item(CMD_TOUCH, 20'h0, 20'h0, 8'h0);
    send_item(CMD_EVICT, 20'h0, 20'h0, 8'h0);
    wait_results_drained();
    known_frames.delete();

    // no idling, with one long hold-off on the result side to back up the input
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random_phase(275);
    wait_results_drained();

    idle_pct  <= 65;
    stall_pct <= 0;
    run_random_phase(275);
    wait_results_drained();

    idle_pct  <= 0;
    stall_pct <= 65;
    run_random_phase(275);
    wait_results_drained();

    idle_pct  <= 12;
    stall_pct <= 12;
    run_random_phase(275);
    wait_results_drained();

    stall_pct <= 0;
    repeat (FRAME_SLOTS + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
